// ----- sv/ucb_pkg.sv -----
// Shared types and constants of the uptime counter bank.
`default_nettype none

package ucb_pkg;

    // Bank geometry
    localparam int MAX_CHANNELS = 16;
    localparam int CH_W         = 4;
    localparam int NUM_W        = $clog2(MAX_CHANNELS + 1);
    localparam int DEF_CHANNELS = 4;

    // Register reset values
    localparam logic [31:0]      SESSION_RESET  = 32'd60000;
    localparam logic [31:0]      SAVE_RESET     = 32'd86400000;
    localparam logic [15:0]      LEAD_RESET     = 16'd1000;
    localparam logic [NUM_W-1:0] CHANNELS_RESET = NUM_W'(DEF_CHANNELS);

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SESSION  = 2'd0;
    localparam logic [1:0] REG_SAVE     = 2'd1;
    localparam logic [1:0] REG_LEAD     = 2'd2;
    localparam logic [1:0] REG_CHANNELS = 2'd3;

    // Item modes
    typedef enum logic [2:0] {
        MODE_UPDATE = 3'd0,
        MODE_INC    = 3'd1,
        MODE_SET    = 3'd2,
        MODE_RESET  = 3'd3,
        MODE_MINUTE = 3'd4
    } ucb_mode_t;

    typedef struct packed {
        logic [2:0]      mode;
        logic [CH_W-1:0] channel;
        logic [31:0]     new_count;
        logic [31:0]     now_ms;
        logic [31:0]     caller_last_mark;
    } ucb_in_t;

    typedef struct packed {
        logic [31:0] count_out;
        logic [31:0] resets_out;
        logic [31:0] mark_out;
        logic        flash_ongoing;
        logic        save_request;
        logic        refused;
    } ucb_out_t;

    typedef struct packed {
        logic [31:0]      session_interval;
        logic [31:0]      save_interval;
        logic [15:0]      save_lead;
        logic [NUM_W-1:0] channel_count;
    } ucb_cfg_t;

endpackage

`default_nettype wire

// ----- sv/ucb_bank.sv -----
// Counter bank state and the single-pass update for one item.
`default_nettype none

module ucb_bank
    import ucb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step_en,
    input  wire ucb_in_t  item,
    input  wire ucb_cfg_t cfg,
    output ucb_out_t      result
);

    logic [31:0] count_reg [MAX_CHANNELS];
    logic [31:0] count_next [MAX_CHANNELS];
    logic [31:0] resets_reg [MAX_CHANNELS];
    logic [31:0] resets_next [MAX_CHANNELS];
    logic [31:0] minute_mark_reg;
    logic [31:0] minute_mark_next;
    logic [31:0] save_mark_reg;
    logic [31:0] save_mark_next;
    logic        flag_reg;
    logic        flag_next;

    logic [NUM_W-1:0] in_use;
    logic             ch_ok;
    logic [31:0]      since_minute;
    logic [31:0]      since_save;
    logic [31:0]      since_caller;
    logic [31:0]      lead_thr;
    logic             minute_hit;
    logic             lead_hit;
    logic             save_hit;
    logic             caller_hit;

    // Clamp the channel count to the usable range
    always_comb
    begin
        if (cfg.channel_count < NUM_W'(DEF_CHANNELS))
            in_use = NUM_W'(DEF_CHANNELS);
        else if (cfg.channel_count > NUM_W'(MAX_CHANNELS))
            in_use = NUM_W'(MAX_CHANNELS);
        else
            in_use = cfg.channel_count;
    end

    assign ch_ok = NUM_W'(item.channel) < in_use;

    // Elapsed-time checks, all on wrapping differences
    assign since_minute = item.now_ms - minute_mark_reg;
    assign since_save   = item.now_ms - save_mark_reg;
    assign since_caller = item.now_ms - item.caller_last_mark;
    assign lead_thr     = ({16'd0, cfg.save_lead} > cfg.save_interval) ? 32'd0
                        : cfg.save_interval - {16'd0, cfg.save_lead};
    assign minute_hit   = since_minute >= cfg.session_interval;
    assign lead_hit     = since_save >= lead_thr;
    assign save_hit     = since_save >= cfg.save_interval;
    assign caller_hit   = since_caller >= cfg.session_interval;

    // Work out the state after this item and the result fields
    always_comb
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            count_next[i]  = count_reg[i];
            resets_next[i] = resets_reg[i];
        end
        minute_mark_next = minute_mark_reg;
        save_mark_next   = save_mark_reg;
        flag_next        = flag_reg;
        result.mark_out      = 32'd0;
        result.save_request  = 1'b0;
        result.refused       = 1'b0;

        case (item.mode)
            MODE_UPDATE:
            begin
                if (minute_hit)
                begin
                    minute_mark_next = item.now_ms;
                    count_next[0] = count_reg[0] + 32'd1;
                    count_next[1] = count_reg[1] + 32'd1;
                    count_next[2] = count_reg[2] + 32'd1;
                end
                if (lead_hit)
                    flag_next = 1'b1;
                // A due save wins over the early warning
                if (save_hit)
                begin
                    save_mark_next      = item.now_ms;
                    flag_next           = 1'b0;
                    result.save_request = 1'b1;
                end
            end
            MODE_INC:
            begin
                if (ch_ok)
                    count_next[item.channel] = count_reg[item.channel] + 32'd1;
                else
                    result.refused = 1'b1;
            end
            MODE_SET:
            begin
                if (ch_ok)
                    count_next[item.channel] = item.new_count;
                else
                    result.refused = 1'b1;
            end
            MODE_RESET:
            begin
                // Channel zero may not be reset
                if (ch_ok && (item.channel != '0))
                begin
                    resets_next[item.channel] = resets_reg[item.channel] + 32'd1;
                    count_next[item.channel]  = 32'd0;
                end
                else
                    result.refused = 1'b1;
            end
            MODE_MINUTE:
            begin
                result.mark_out = item.caller_last_mark;
                if (ch_ok)
                begin
                    if (caller_hit)
                    begin
                        result.mark_out = item.now_ms;
                        count_next[item.channel] = count_reg[item.channel] + 32'd1;
                    end
                end
                else
                    result.refused = 1'b1;
            end
            default:
                result.refused = 1'b1;
        endcase

        result.count_out     = ch_ok ? count_next[item.channel] : 32'd0;
        result.resets_out    = ch_ok ? resets_next[item.channel] : 32'd0;
        result.flash_ongoing = flag_next;
    end

    // Commit the new state when the item leaves the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                count_reg[i]  <= 32'd0;
                resets_reg[i] <= 32'd0;
            end
            minute_mark_reg <= 32'd0;
            save_mark_reg   <= 32'd0;
            flag_reg        <= 1'b0;
        end
        else if (step_en)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                count_reg[i]  <= count_next[i];
                resets_reg[i] <= resets_next[i];
            end
            minute_mark_reg <= minute_mark_next;
            save_mark_reg   <= save_mark_next;
            flag_reg        <= flag_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/uptime_counter_bank_core.sv -----
// Uptime counter bank: input register, one update pass, result register.
// An item goes from the input register through the update to the result register.
// Throughput: one item per cycle if not stalled; the counter bank update is a single pass.
// A held result blocks the input register only when both are full and out_stall is high.
// Reset: asynchronous, active low; all counters, marks and the flag clear to zero,
// and the registers return to 60000, 86400000, 1000 and 4 channels.
`default_nettype none

module uptime_counter_bank_core
    import ucb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire ucb_in_t     in_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output ucb_out_t         out_item,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    ucb_cfg_t cfg_reg;
    logic     stage_valid_reg;
    ucb_in_t  stage_item_reg;
    logic     out_valid_reg;
    ucb_out_t out_item_reg;
    ucb_out_t step_result;
    logic     stage_advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.session_interval <= SESSION_RESET;
            cfg_reg.save_interval    <= SAVE_RESET;
            cfg_reg.save_lead        <= LEAD_RESET;
            cfg_reg.channel_count    <= CHANNELS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SESSION:  cfg_reg.session_interval <= cfg_data;
                REG_SAVE:     cfg_reg.save_interval    <= cfg_data;
                REG_LEAD:     cfg_reg.save_lead        <= cfg_data[15:0];
                REG_CHANNELS: cfg_reg.channel_count    <= cfg_data[NUM_W-1:0];
                default:      cfg_reg.session_interval <= cfg_reg.session_interval;
            endcase
        end
    end

    // Advance the stage whenever the result register is free or draining
    assign stage_advance = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall      = stage_valid_reg && !stage_advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (!in_stall)
            stage_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            stage_item_reg <= in_item;
    end

    ucb_bank u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (stage_advance),
        .item    (stage_item_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    // Result register: hold while stalled, load on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stage_advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_advance)
            out_item_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_save_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.save_request |-> !out_item_reg.flash_ongoing)
        else $error("save request with flag still set");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        stage_advance |=> out_valid_reg)
        else $error("advanced item did not reach the result register");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> stage_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

// ----- verif/ucb_result_checker.sv -----
// Result checker for the uptime counter bank: predicts every item's result and compares it.
`timescale 1ns / 100ps

module ucb_result_checker
    import ucb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  ucb_in_t     in_item,
    input  logic        out_valid,
    input  logic        out_stall,
    input  ucb_out_t    out_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          results_checked,
    output int          saves_seen,
    output int          refusals_seen
);

    // Shadow copies of the configuration registers
    logic [31:0]      session_ms;
    logic [31:0]      save_ms;
    logic [15:0]      lead_ms;
    logic [NUM_W-1:0] ch_count;

    // Shadow copy of the counter bank
    logic [31:0] counts [MAX_CHANNELS];
    logic [31:0] reset_counts [MAX_CHANNELS];
    logic [31:0] minute_mark;
    logic [31:0] save_mark;
    logic        ongoing;

    ucb_out_t due_results [$];
    ucb_out_t oldest;
    int       fail_total    = 0;
    int       checked_total = 0;
    int       save_total    = 0;
    int       refused_total = 0;

    assign errors          = fail_total;
    assign results_checked = checked_total;
    assign saves_seen      = save_total;
    assign refusals_seen   = refused_total;

    // Advance the shadow bank by one item and return the result it should produce
    function automatic ucb_out_t bank_step(input ucb_in_t it);
        ucb_out_t    res;
        int          live;
        logic        in_use;
        logic [31:0] since_minute;
        logic [31:0] since_save;
        logic [31:0] lead_thr;
        res  = '0;
        live = int'(ch_count);
        if (live < DEF_CHANNELS)
            live = DEF_CHANNELS;
        if (live > MAX_CHANNELS)
            live = MAX_CHANNELS;
        in_use = int'(it.channel) < live;

        case (it.mode)
            MODE_UPDATE:
            begin
                since_minute = it.now_ms - minute_mark;
                if (since_minute >= session_ms)
                begin
                    minute_mark = it.now_ms;
                    counts[0]   = counts[0] + 32'd1;
                    counts[1]   = counts[1] + 32'd1;
                    counts[2]   = counts[2] + 32'd1;
                end
                since_save = it.now_ms - save_mark;
                // Lead larger than the interval pins the flag threshold at zero
                if (32'(lead_ms) > save_ms)
                    lead_thr = '0;
                else
                    lead_thr = save_ms - 32'(lead_ms);
                if (since_save >= lead_thr)
                    ongoing = 1'b1;
                // The save wins when both thresholds are crossed together
                if (since_save >= save_ms)
                begin
                    save_mark        = it.now_ms;
                    res.save_request = 1'b1;
                    ongoing          = 1'b0;
                end
            end
            MODE_INC:
            begin
                if (in_use)
                    counts[it.channel] = counts[it.channel] + 32'd1;
                else
                    res.refused = 1'b1;
            end
            MODE_SET:
            begin
                if (in_use)
                    counts[it.channel] = it.new_count;
                else
                    res.refused = 1'b1;
            end
            MODE_RESET:
            begin
                // Channel zero never takes a reset
                if (in_use && it.channel != '0)
                begin
                    reset_counts[it.channel] = reset_counts[it.channel] + 32'd1;
                    counts[it.channel]       = '0;
                end
                else
                begin
                    res.refused = 1'b1;
                end
            end
            MODE_MINUTE:
            begin
                res.mark_out = it.caller_last_mark;
                if (!in_use)
                begin
                    res.refused = 1'b1;
                end
                else if (it.now_ms - it.caller_last_mark >= session_ms)
                begin
                    res.mark_out       = it.now_ms;
                    counts[it.channel] = counts[it.channel] + 32'd1;
                end
            end
            default:
            begin
                res.refused = 1'b1;
            end
        endcase

        if (in_use)
        begin
            res.count_out  = counts[it.channel];
            res.resets_out = reset_counts[it.channel];
        end
        res.flash_ongoing = ongoing;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            fail_total++;
        end
    endtask

    // Track configuration writes, predict accepted items, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_ms  = SESSION_RESET;
            save_ms     = SAVE_RESET;
            lead_ms     = LEAD_RESET;
            ch_count    = CHANNELS_RESET;
            minute_mark = '0;
            save_mark   = '0;
            ongoing     = 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                counts[i]       = '0;
                reset_counts[i] = '0;
            end
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SESSION:  session_ms = cfg_data;
                    REG_SAVE:     save_ms    = cfg_data;
                    REG_LEAD:     lead_ms    = cfg_data[15:0];
                    REG_CHANNELS: ch_count   = cfg_data[NUM_W-1:0];
                    default:      ;
                endcase
            end

            // Compare first so a result never meets the item taken at the same edge
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result with no item outstanding: count_out 0x%08h",
                           out_item.count_out);
                    fail_total++;
                end
                else
                begin
                    oldest = due_results.pop_front();
                    check_field("count_out", oldest.count_out, out_item.count_out);
                    check_field("resets_out", oldest.resets_out, out_item.resets_out);
                    check_field("mark_out", oldest.mark_out, out_item.mark_out);
                    check_field("flash_ongoing", 32'(oldest.flash_ongoing),
                                32'(out_item.flash_ongoing));
                    check_field("save_request", 32'(oldest.save_request),
                                32'(out_item.save_request));
                    check_field("refused", 32'(oldest.refused), 32'(out_item.refused));
                    checked_total++;
                    if (oldest.save_request)
                        save_total++;
                    if (oldest.refused)
                        refused_total++;
                end
            end

            if (in_valid && !in_stall)
                due_results.push_back(bank_step(in_item));

            pending <= due_results.size();
        end
    end

endmodule

// ----- verif/tb_uptime_counter_bank_core.sv -----
// Testbench top for the uptime counter bank: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_uptime_counter_bank_core;
    import ucb_pkg::*;

    localparam logic [2:0] MODE_FIRST_UNDEF = 3'(MODE_MINUTE) + 3'd1;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    ucb_in_t     in_item   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    ucb_out_t    out_item;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_SESSION;
    logic [31:0] cfg_data  = '0;

    int errors;
    int pending;
    int results_checked;
    int saves_seen;
    int refusals_seen;

    // Stimulus shaping state
    logic [31:0] tick       = '0;
    logic [31:0] step_max   = 32'd1000;
    logic [31:0] mark_span  = 32'd1000;
    int          live_chans = DEF_CHANNELS;
    logic        steady     = 1'b0;
    int          items_sent = 0;
    int          settings   = 1;
    int          stall_run  = 0;
    int          stall_pick;
    logic [31:0] sess_val;
    logic [31:0] save_val;
    logic [31:0] lead_val;
    logic [31:0] chan_val;

    uptime_counter_bank_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ucb_result_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_item        (out_item),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .errors          (errors),
        .pending         (pending),
        .results_checked (results_checked),
        .saves_seen      (saves_seen),
        .refusals_seen   (refusals_seen)
    );

    always #1 clk = ~clk;

    // Hard stop in case the block hangs
    initial
    begin
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Stall the result side in runs: mostly short, a few long, some long free stretches
    always @(posedge clk)
    begin
        if (stall_run > 0)
        begin
            stall_run <= stall_run - 1;
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 50)
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(0, 8);
            end
            else if (stall_pick < 90)
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(0, 2);
            end
            else if (stall_pick < 95)
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(5, 30);
            end
            else
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(20, 60);
            end
        end
    end

    function automatic ucb_in_t make_item(input logic [2:0] mode, input logic [CH_W-1:0] ch,
                                          input logic [31:0] count, now, caller_mark);
        ucb_in_t it;
        it.mode             = mode;
        it.channel          = ch;
        it.new_count        = count;
        it.now_ms           = now;
        it.caller_last_mark = caller_mark;
        return it;
    endfunction

    // Offer one item after a random gap and hold it until the block takes it
    task automatic send_item(input ucb_in_t it);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (steady || pick < 60)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(5, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write all four registers on consecutive edges
    task automatic set_config(input logic [31:0] sess, save, lead, chans);
        logic [31:0] vals [4];
        logic [1:0]  idx [4];
        int          n;
        vals = '{sess, save, lead, chans};
        idx  = '{REG_SESSION, REG_SAVE, REG_LEAD, REG_CHANNELS};
        for (int r = 0; r < 4; r++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[r];
            cfg_data  <= vals[r];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        n = int'(chans[NUM_W-1:0]);
        if (n < DEF_CHANNELS)
            n = DEF_CHANNELS;
        if (n > MAX_CHANNELS)
            n = MAX_CHANNELS;
        live_chans = n;
        steady     = ($urandom_range(0, 3) == 0);
        settings++;
    endtask

    // Random items around a time base that moves forward, with some noise mixed in
    task automatic run_phase(input int n_items);
        ucb_in_t it;
        int      pick;
        for (int k = 0; k < n_items; k++)
        begin
            pick                = $urandom_range(0, 99);
            it.new_count        = $urandom;
            it.now_ms           = tick;
            it.caller_last_mark = $urandom;
            if ($urandom_range(0, 3) != 0)
                it.channel = CH_W'($urandom_range(0, live_chans - 1));
            else
                it.channel = CH_W'($urandom);

            if (pick < 45)
            begin
                it.mode = MODE_UPDATE;
                tick    = tick + $urandom_range(0, step_max);
                if ($urandom_range(0, 9) == 0)
                    it.now_ms = $urandom;
                else
                    it.now_ms = tick;
            end
            else if (pick < 60)
            begin
                it.mode = MODE_INC;
            end
            else if (pick < 70)
            begin
                it.mode = MODE_SET;
                // Park some counts just below the wrap so increments roll over
                if ($urandom_range(0, 1) == 0)
                    it.new_count = 32'hFFFF_FFFF - $urandom_range(0, 3);
            end
            else if (pick < 78)
            begin
                it.mode = MODE_RESET;
            end
            else if (pick < 93)
            begin
                it.mode             = MODE_MINUTE;
                it.caller_last_mark = tick - $urandom_range(0, mark_span);
            end
            else
            begin
                it.mode = MODE_FIRST_UNDEF + 3'($urandom_range(0, 2));
            end
            send_item(it);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset configuration
        send_item(make_item(MODE_UPDATE, 4'd0, 32'd0, 32'd0, 32'd0));
        send_item(make_item(MODE_UPDATE, 4'd1, 32'd0, 32'd59999, 32'd0));
        send_item(make_item(MODE_UPDATE, 4'd2, 32'd0, 32'd60000, 32'd0));
        send_item(make_item(MODE_INC, 4'd3, 32'd0, 32'd60000, 32'd0));
        send_item(make_item(MODE_INC, 4'd4, 32'd0, 32'd60000, 32'd0));
        send_item(make_item(MODE_SET, 4'd0, 32'hFFFF_FFFF, 32'd60000, 32'd0));
        send_item(make_item(MODE_INC, 4'd0, 32'd0, 32'd60000, 32'd0));
        send_item(make_item(MODE_SET, 4'd15, 32'h1234_5678, 32'd60000, 32'd0));
        send_item(make_item(MODE_RESET, 4'd0, 32'd0, 32'd60000, 32'd0));
        send_item(make_item(MODE_RESET, 4'd3, 32'd0, 32'd60000, 32'd0));
        send_item(make_item(MODE_MINUTE, 4'd1, 32'd0, 32'd200000, 32'd100000));
        send_item(make_item(MODE_MINUTE, 4'd2, 32'd0, 32'd200000, 32'd150000));
        send_item(make_item(MODE_MINUTE, 4'd3, 32'd0, 32'd200000, 32'd140000));
        send_item(make_item(MODE_MINUTE, 4'd7, 32'd0, 32'd200000, 32'hDEAD_BEEF));
        for (int k = 0; k < 3; k++)
            send_item(make_item(MODE_FIRST_UNDEF + 3'(k), 4'd1, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(MODE_UPDATE, 4'd0, 32'd0, 32'd86399000, 32'd0));
        send_item(make_item(MODE_UPDATE, 4'd1, 32'd0, 32'd86399999, 32'd0));
        send_item(make_item(MODE_UPDATE, 4'd2, 32'd0, 32'd86400000, 32'd0));
        send_item(make_item(MODE_UPDATE, 4'd2, 32'd0, 32'hFFFF_FFFF, 32'd0));
        send_item(make_item(MODE_UPDATE, 4'd3, 32'd0, 32'd5, 32'd0));
        send_item(make_item(MODE_SET, 4'd1, 32'd0, 32'd5, 32'd0));
        send_item(make_item(MODE_UPDATE, 4'd15, 32'd0, 32'd6, 32'd0));

        // Low extremes: zero intervals, lead far above the interval, channels below range
        wait_drained();
        set_config(32'd0, 32'd0, ($urandom & 32'hFFFF_0000) | 32'h0000_FFFF,
                   $urandom << NUM_W);
        tick      = $urandom;
        step_max  = 32'd1000;
        mark_span = 32'd1000;
        run_phase(100);

        // High extremes: full-scale intervals, no lead, channel count past the bank
        wait_drained();
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom & 32'hFFFF_0000, 32'hFFFF_FFFF);
        tick      = $urandom;
        step_max  = 32'hFFFF_FFFF;
        mark_span = 32'hFFFF_FFFF;
        run_phase(100);

        // Short intervals so minute marks, flags and saves happen often
        for (int p = 0; p < 5; p++)
        begin
            wait_drained();
            sess_val = $urandom_range(1, 200);
            save_val = $urandom_range(20, 600);
            lead_val = ($urandom & 32'hFFFF_0000) | $urandom_range(0, 700);
            chan_val = ($urandom << NUM_W) | $urandom_range(0, 31);
            set_config(sess_val, save_val, lead_val, chan_val);
            if ($urandom_range(0, 1) == 0)
                tick = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            else
                tick = $urandom;
            step_max  = sess_val + sess_val / 2;
            mark_span = 2 * sess_val;
            run_phase(120);
        end

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Covered %0d items over %0d register settings, %0d results checked.",
                 items_sent, settings, results_checked);
        $display("Seen %0d save requests and %0d refused items.", saves_seen, refusals_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- uptime_counter_bank_core.f -----
sv/ucb_pkg.sv
sv/ucb_bank.sv
sv/uptime_counter_bank_core.sv
verif/ucb_result_checker.sv
verif/tb_uptime_counter_bank_core.sv
